// ----- rtl/smk_pkg.sv -----
// Shared types and constants of the serial mouse/key event parser.
// No dependencies; every other file of the block imports this package.
package smk_pkg;

	// Pointer coordinate width and fixed field widths
	localparam int COORD_BITS  = 12;
	localparam int BYTE_BITS   = 8;
	localparam int DELTA_BITS  = 7;
	localparam int SCREEN_BITS = 12;

	// Configuration port
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [1:0] REG_MARKER_MASK   = 2'd0;
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

	// Register reset values
	localparam logic [BYTE_BITS-1:0]   MARKER_MASK_RST   = 8'h80;
	localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 12'd640;
	localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 12'd480;

	// Event kind codes
	localparam logic EVENT_KEY   = 1'b0;
	localparam logic EVENT_MOUSE = 1'b1;

	typedef struct packed {
		logic [BYTE_BITS-1:0]   marker_mask;
		logic [SCREEN_BITS-1:0] screen_width;
		logic [SCREEN_BITS-1:0] screen_height;
	} smk_cfg_t;

endpackage

// ----- rtl/smk_cfg_regs.sv -----
// APB-style configuration registers: marker mask and screen size.
// Depends on smk_pkg.
module smk_cfg_regs
	import smk_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output smk_cfg_t                 cfg
);

	smk_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.marker_mask   <= MARKER_MASK_RST;
			cfg_q.screen_width  <= SCREEN_WIDTH_RST;
			cfg_q.screen_height <= SCREEN_HEIGHT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MARKER_MASK:   cfg_q.marker_mask   <= pwdata[BYTE_BITS-1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[SCREEN_BITS-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[SCREEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MARKER_MASK:
				prdata = {{(APB_DATA_BITS-BYTE_BITS){1'b0}}, cfg_q.marker_mask};
			REG_SCREEN_WIDTH:
				prdata = {{(APB_DATA_BITS-SCREEN_BITS){1'b0}}, cfg_q.screen_width};
			REG_SCREEN_HEIGHT:
				prdata = {{(APB_DATA_BITS-SCREEN_BITS){1'b0}}, cfg_q.screen_height};
			default:
				prdata = '0;
		endcase
	end

endmodule

// ----- rtl/smk_axis_clamp.sv -----
// One pointer axis: add a 7-bit signed delta and clamp to 0 .. size-1.
// Depends on smk_pkg.
module smk_axis_clamp
	import smk_pkg::*;
#(
	parameter int CoordBits = COORD_BITS
) (
	input  logic [CoordBits-1:0]   pos,
	input  logic [DELTA_BITS-1:0]  delta,
	input  logic [SCREEN_BITS-1:0] size,
	output logic [CoordBits-1:0]   result
);

	localparam int SumBits = ((CoordBits > SCREEN_BITS) ? CoordBits : SCREEN_BITS) + 2;

	logic signed [SumBits-1:0] sum;
	logic signed [SumBits-1:0] lim_raw;
	logic signed [SumBits-1:0] coord_max;
	logic signed [SumBits-1:0] lim;

	assign sum = {{(SumBits-CoordBits){1'b0}}, pos}
		+ {{(SumBits-DELTA_BITS){delta[DELTA_BITS-1]}}, delta};

	// A zero size holds the axis at zero
	assign lim_raw = (size == '0) ? '0
		: {{(SumBits-SCREEN_BITS){1'b0}}, size - SCREEN_BITS'(1)};
	assign coord_max = {{(SumBits-CoordBits){1'b0}}, {CoordBits{1'b1}}};
	assign lim = (lim_raw > coord_max) ? coord_max : lim_raw;

	always_comb begin
		if (sum[SumBits-1]) begin
			result = '0;
		end else if (sum > lim) begin
			result = lim[CoordBits-1:0];
		end else begin
			result = sum[CoordBits-1:0];
		end
	end

endmodule

// ----- rtl/smk_decoder.sv -----
// Packet state machine, pointer position and result register.
// Depends on smk_pkg and smk_axis_clamp.
module smk_decoder
	import smk_pkg::*;
#(
	parameter int CoordBits = COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smk_cfg_t               cfg,
	input  logic                   take,
	input  logic [BYTE_BITS-1:0]   byte_in,
	input  logic                   res_ready,
	output logic                   res_valid,
	output logic                   event_kind,
	output logic [BYTE_BITS-1:0]   key_char,
	output logic [BYTE_BITS-1:0]   button_bits,
	output logic [CoordBits-1:0]   pointer_x,
	output logic [CoordBits-1:0]   pointer_y,
	output logic                   double_click
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_X    = 2'd1,
		PH_Y    = 2'd2
	} phase_t;

	phase_t                phase_q;
	logic [BYTE_BITS-1:0]  first_byte_q;
	logic [DELTA_BITS-1:0] second_byte_q;
	logic [CoordBits-1:0]  pos_x_q;
	logic [CoordBits-1:0]  pos_y_q;
	logic [CoordBits-1:0]  next_x;
	logic [CoordBits-1:0]  next_y;
	logic                  is_marker;
	logic                  emit;

	logic                  res_valid_q;
	logic                  event_kind_q;
	logic [BYTE_BITS-1:0]  key_char_q;
	logic [BYTE_BITS-1:0]  button_bits_q;
	logic [CoordBits-1:0]  pointer_x_q;
	logic [CoordBits-1:0]  pointer_y_q;
	logic                  double_click_q;

	assign is_marker = (byte_in & cfg.marker_mask) == cfg.marker_mask;

	// A taken byte yields an event on the third packet byte or as a key
	assign emit = take && (phase_q == PH_Y || (phase_q != PH_X && !is_marker));

	smk_axis_clamp #(.CoordBits(CoordBits)) u_clamp_x (
		.pos    (pos_x_q),
		.delta  (second_byte_q),
		.size   (cfg.screen_width),
		.result (next_x)
	);

	smk_axis_clamp #(.CoordBits(CoordBits)) u_clamp_y (
		.pos    (pos_y_q),
		.delta  (byte_in[DELTA_BITS-1:0]),
		.size   (cfg.screen_height),
		.result (next_y)
	);

	// Control state and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			first_byte_q  <= '0;
			second_byte_q <= '0;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (take) begin
				case (phase_q)
					PH_Y: begin
						pos_x_q <= next_x;
						pos_y_q <= next_y;
						phase_q <= PH_IDLE;
					end
					PH_X: begin
						second_byte_q <= byte_in[DELTA_BITS-1:0];
						phase_q       <= PH_Y;
					end
					default: begin
						if (is_marker) begin
							first_byte_q <= byte_in;
							phase_q      <= PH_X;
						end else begin
							phase_q <= PH_IDLE;
						end
					end
				endcase
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (phase_q == PH_Y) begin
				event_kind_q   <= EVENT_MOUSE;
				key_char_q     <= '0;
				button_bits_q  <= first_byte_q & ~cfg.marker_mask;
				pointer_x_q    <= next_x;
				pointer_y_q    <= next_y;
				double_click_q <= byte_in[BYTE_BITS-1];
			end else if (phase_q != PH_X && !is_marker) begin
				event_kind_q   <= EVENT_KEY;
				key_char_q     <= byte_in;
				button_bits_q  <= '0;
				pointer_x_q    <= '0;
				pointer_y_q    <= '0;
				double_click_q <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign event_kind   = event_kind_q;
	assign key_char     = key_char_q;
	assign button_bits  = button_bits_q;
	assign pointer_x    = pointer_x_q;
	assign pointer_y    = pointer_y_q;
	assign double_click = double_click_q;

endmodule

// ----- rtl/serial_mouse_key_event_parser_unit.sv -----
// Top level of the serial mouse/key event parser.
// Depends on smk_pkg, smk_cfg_regs and smk_decoder.
//
// Usage:
//   Feed received serial bytes on the input channel (serial_byte, in_valid,
//   in_ready). While no packet is open, a byte that has every marker_mask
//   bit set opens a three-byte mouse packet; any other byte comes out as a
//   key event. The second and third bytes carry 7-bit signed X and Y deltas;
//   bit 7 of the third byte is the double-click flag. After the third byte
//   the pointer moves by both deltas, is clamped to the screen, and a mouse
//   event goes out on the output channel (out_valid, out_ready).
//   The input register loads at the accepting edge and the result register
//   loads from it once free or being drained, raising out_valid when the
//   byte completes an event. Throughput: one byte per cycle while the
//   receiver does not stall; X and Y each have an add-and-clamp path there.
//   When the receiver stalls, the result register holds its transaction and
//   the input register fills; in_ready drops only once both are full.
//   Reset clears the packet state and the pointer to zero and loads
//   marker_mask 0x80, screen 640 x 480. Write the registers through the APB
//   port (addresses 0, 4, 8) only while no transaction is in flight.
module serial_mouse_key_event_parser_unit
	import smk_pkg::*;
#(
	parameter int CoordBits = COORD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// APB configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	// Input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [BYTE_BITS-1:0]     serial_byte,
	// Output channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     event_kind,
	output logic [BYTE_BITS-1:0]     key_char,
	output logic [BYTE_BITS-1:0]     button_bits,
	output logic [CoordBits-1:0]     pointer_x,
	output logic [CoordBits-1:0]     pointer_y,
	output logic                     double_click
);

	smk_cfg_t             cfg;
	logic                 valid_s1;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 take;

	smk_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the input register whenever the result register is free or
	// being drained this cycle.
	assign take     = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the byte payload; no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= serial_byte;
		end
	end

	smk_decoder #(.CoordBits(CoordBits)) u_dec (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.take         (take),
		.byte_in      (byte_s1),
		.res_ready    (out_ready),
		.res_valid    (out_valid),
		.event_kind   (event_kind),
		.key_char     (key_char),
		.button_bits  (button_bits),
		.pointer_x    (pointer_x),
		.pointer_y    (pointer_y),
		.double_click (double_click)
	);

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for serial_mouse_key_event_parser_unit.
// Depends on smk_pkg and the RTL of the block; a queue-fed driver, a monitor and
// an internal decoder model check every key and mouse event field by field.
module testbench;
	import smk_pkg::*;

	localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
	localparam int DRAIN_CYCLES    = 8;     // two-stage pipeline plus margin
	localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no transaction at all
	localparam int RANDOM_PHASES   = 6;
	localparam int BYTES_PER_PHASE = 140;
	localparam int MAX_REPORTS     = 10;

	// One decoded event as it leaves the block
	typedef struct packed {
		logic                   kind;
		logic [BYTE_BITS-1:0]   key;
		logic [BYTE_BITS-1:0]   buttons;
		logic [COORD_BITS-1:0]  x;
		logic [COORD_BITS-1:0]  y;
		logic                   dbl;
	} mk_event_t;

	typedef enum logic [1:0] {
		PKT_IDLE   = 2'd0,
		PKT_WAIT_X = 2'd1,
		PKT_WAIT_Y = 2'd2
	} pkt_phase_t;

	// Clock, reset and every block input start at a known value
	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     psel        = 1'b0;
	logic                     penable     = 1'b0;
	logic                     pwrite      = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr       = '0;
	logic [APB_DATA_BITS-1:0] pwdata      = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic [BYTE_BITS-1:0]     serial_byte = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic                     event_kind;
	logic [BYTE_BITS-1:0]     key_char;
	logic [BYTE_BITS-1:0]     button_bits;
	logic [COORD_BITS-1:0]    pointer_x;
	logic [COORD_BITS-1:0]    pointer_y;
	logic                     double_click;

	serial_mouse_key_event_parser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.serial_byte  (serial_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.key_char     (key_char),
		.button_bits  (button_bits),
		.pointer_x    (pointer_x),
		.pointer_y    (pointer_y),
		.double_click (double_click)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bytes waiting to be sent and events waiting to come out
	logic [BYTE_BITS-1:0] pending_bytes[$];
	mk_event_t            expected_events[$];

	// Idle percentages of sender and receiver, changed between phases
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	// Decoder model: register copies and packet state, all at reset values
	logic [BYTE_BITS-1:0]   cfg_marker = MARKER_MASK_RST;
	logic [SCREEN_BITS-1:0] cfg_width  = SCREEN_WIDTH_RST;
	logic [SCREEN_BITS-1:0] cfg_height = SCREEN_HEIGHT_RST;
	pkt_phase_t             pkt_phase  = PKT_IDLE;
	logic [BYTE_BITS-1:0]   held_first = '0;
	logic [DELTA_BITS-1:0]  held_x     = '0;
	logic [COORD_BITS-1:0]  pos_x      = '0;
	logic [COORD_BITS-1:0]  pos_y      = '0;

	// Run statistics
	int errors        = 0;
	int bytes_sent    = 0;
	int keys_checked  = 0;
	int mice_checked  = 0;
	int clamps_low    = 0;
	int clamps_high   = 0;
	int reg_writes    = 0;
	int stall_cycles  = 0;

	function automatic int signed_delta(input logic [DELTA_BITS-1:0] v);
		return int'(v) - (v[DELTA_BITS-1] ? 128 : 0);
	endfunction

	// Clamp to 0 .. size-1, a zero size acting as one, capped at the coordinate range
	function automatic logic [COORD_BITS-1:0] clamp_coord(input int p,
			input logic [SCREEN_BITS-1:0] size);
		int lim;
		lim = (size == '0) ? 0 : int'(size) - 1;
		if (lim > COORD_MAX)
			lim = COORD_MAX;
		if (p < 0)
			return '0;
		if (p > lim)
			return COORD_BITS'(lim);
		return COORD_BITS'(p);
	endfunction

	function automatic string event_text(input mk_event_t ev);
		return $sformatf("kind=%0d key=%02h btn=%02h x=%0d y=%0d dbl=%0d",
			ev.kind, ev.key, ev.buttons, ev.x, ev.y, ev.dbl);
	endfunction

	// Advance the decoder model by one accepted byte and queue any event it yields
	task automatic decode_serial_byte(input logic [BYTE_BITS-1:0] b);
		mk_event_t ev;
		int raw_x;
		int raw_y;
		ev = '0;
		case (pkt_phase)
			PKT_WAIT_Y: begin
				raw_x = int'(pos_x) + signed_delta(held_x);
				raw_y = int'(pos_y) + signed_delta(b[DELTA_BITS-1:0]);
				pos_x = clamp_coord(raw_x, cfg_width);
				pos_y = clamp_coord(raw_y, cfg_height);
				if (raw_x < 0)
					clamps_low++;
				else if (raw_x != int'(pos_x))
					clamps_high++;
				if (raw_y < 0)
					clamps_low++;
				else if (raw_y != int'(pos_y))
					clamps_high++;
				pkt_phase  = PKT_IDLE;
				ev.kind    = EVENT_MOUSE;
				ev.buttons = held_first & ~cfg_marker;
				ev.x       = pos_x;
				ev.y       = pos_y;
				ev.dbl     = b[BYTE_BITS-1];
				expected_events.push_back(ev);
			end
			PKT_WAIT_X: begin
				// data bytes are taken as they are, marker bits or not
				held_x    = b[DELTA_BITS-1:0];
				pkt_phase = PKT_WAIT_Y;
			end
			default: begin
				if ((b & cfg_marker) == cfg_marker) begin
					held_first = b;
					pkt_phase  = PKT_WAIT_X;
				end else begin
					ev.kind = EVENT_KEY;
					ev.key  = b;
					expected_events.push_back(ev);
				end
			end
		endcase
	endtask

	// Driver: present the next pending byte, hold it until accepted, idle at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			serial_byte <= '0;
		end else begin
			if (in_valid && in_ready) begin
				decode_serial_byte(serial_byte);
				bytes_sent++;
			end
			// the slot is free once nothing is shown or the shown byte just left
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					serial_byte <= pending_bytes.pop_front();
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each outgoing event with the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin
		mk_event_t got;
		mk_event_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{kind: event_kind, key: key_char, buttons: button_bits,
					x: pointer_x, y: pointer_y, dbl: double_click};
				if (expected_events.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected event: %s", event_text(got));
				end else begin
					want = expected_events.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("event mismatch: expected %s, actual %s",
								event_text(want), event_text(got));
					end
					if (want.kind == EVENT_MOUSE)
						mice_checked++;
					else
						keys_checked++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: count cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Register write over APB: setup cycle, then access cycle; lands at the access edge
	task automatic apb_write(input logic [1:0] reg_index, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_BITS'({reg_index, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_index)
			REG_MARKER_MASK:   cfg_marker = value[BYTE_BITS-1:0];
			REG_SCREEN_WIDTH:  cfg_width  = value[SCREEN_BITS-1:0];
			REG_SCREEN_HEIGHT: cfg_height = value[SCREEN_BITS-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic write_screen_setup(input logic [BYTE_BITS-1:0] mask,
			input logic [SCREEN_BITS-1:0] width, input logic [SCREEN_BITS-1:0] height);
		apb_write(REG_MARKER_MASK, 32'(mask));
		apb_write(REG_SCREEN_WIDTH, 32'(width));
		apb_write(REG_SCREEN_HEIGHT, 32'(height));
	endtask

	// Wait until every byte is accepted and every event is out, then let the pipe empty;
	// look at the falling edge so the driver and monitor updates have settled
	task automatic drain_pipeline();
		while (pending_bytes.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Delta byte: half the time full random, else a large step either way to hit the edges
	function automatic logic [BYTE_BITS-1:0] random_delta_byte();
		logic [BYTE_BITS-1:0] d;
		d = BYTE_BITS'($urandom_range(255));
		case ($urandom_range(3))
			2: d[DELTA_BITS-1:0] = DELTA_BITS'(7'h30 + $urandom_range(15));
			3: d[DELTA_BITS-1:0] = DELTA_BITS'(7'h40 + $urandom_range(15));
			default: ;
		endcase
		return d;
	endfunction

	// Mostly well-formed packets with random content, the rest key bytes and stray openers
	task automatic queue_random_traffic(input int count);
		logic [BYTE_BITS-1:0] b;
		int k;
		int queued;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(99) < 70) begin
				pending_bytes.push_back(BYTE_BITS'($urandom_range(255)) | cfg_marker);
				pending_bytes.push_back(random_delta_byte());
				pending_bytes.push_back(random_delta_byte());
				queued += 3;
			end else begin
				b = BYTE_BITS'($urandom_range(255));
				// drop one marker bit most of the time so the byte stays a key
				if (cfg_marker != '0 && $urandom_range(99) < 85) begin
					do
						k = $urandom_range(BYTE_BITS - 1);
					while (!cfg_marker[k]);
					b[k] = 1'b0;
				end
				pending_bytes.push_back(b);
				queued++;
			end
		end
	endtask

	initial begin
		logic [BYTE_BITS-1:0]   mask;
		logic [SCREEN_BITS-1:0] width;
		logic [SCREEN_BITS-1:0] height;
		int ph;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 55;

		// Reset setup: keys at both ends of the range, packets with extreme deltas,
		// a clamp at the low edge, data bytes that carry the marker bit
		pending_bytes = '{8'h00, 8'h7F, 8'h55,
			8'h80, 8'h3F, 8'h3F,
			8'hFF, 8'h40, 8'hC0,
			8'h81, 8'h3F, 8'h3F,
			8'hC2, 8'hFF, 8'h80,
			8'h2A};
		drain_pipeline();

		// Zero marker mask opens a packet on every byte; zero width pins X at zero
		write_screen_setup(8'h00, 12'd0, 12'd4095);
		pending_bytes = '{8'h00, 8'h3F, 8'h3F,
			8'h12, 8'h3F, 8'hBF,
			8'h7F, 8'h01, 8'h40};
		drain_pipeline();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			// receiver idles most first, then the sender, then neither
			case (ph / 2)
				0: begin send_idle_pct = 12; recv_idle_pct = 55; end
				1: begin send_idle_pct = 55; recv_idle_pct = 12; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (ph)
				0: begin mask = 8'h80; width = 12'd640;  height = 12'd480; end
				1: begin mask = 8'hFF; width = 12'd4095; height = 12'd1;   end
				2: begin
					mask   = BYTE_BITS'($urandom_range(255));
					width  = SCREEN_BITS'($urandom_range(64, 1));
					height = SCREEN_BITS'($urandom_range(64, 1));
				end
				3: begin mask = 8'h00; width = 12'd1; height = 12'd4095; end
				4: begin
					mask   = 8'h03;
					width  = SCREEN_BITS'($urandom_range(4095, 1));
					height = SCREEN_BITS'($urandom_range(200, 1));
				end
				default: begin
					mask   = BYTE_BITS'($urandom_range(255)) | 8'h40;
					width  = 12'd0;
					height = SCREEN_BITS'($urandom_range(200, 1));
				end
			endcase
			write_screen_setup(mask, width, height);
			queue_random_traffic(BYTES_PER_PHASE);
			drain_pipeline();
		end

		$display("Sent %0d serial bytes; checked %0d key and %0d mouse events",
			bytes_sent, keys_checked, mice_checked);
		$display("after %0d register writes; pointer hit the low edge %0d and the high edge %0d times.",
			reg_writes, clamps_low, clamps_high);
		if (errors == 0 && expected_events.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d events still expected", errors,
				expected_events.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/smk_pkg.sv
rtl/smk_cfg_regs.sv
rtl/smk_axis_clamp.sv
rtl/smk_decoder.sv
rtl/serial_mouse_key_event_parser_unit.sv
tb/sv/testbench.sv
